[rtl/core/tof_to_longitudinal_momentum_macros.svh]
// assertion macros shared by the tof to momentum checker
// no dependencies
`ifndef TOF_TO_LONGITUDINAL_MOMENTUM_MACROS_SVH
`define TOF_TO_LONGITUDINAL_MOMENTUM_MACROS_SVH

// same-cycle implication, disabled in reset
`define TLM_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlm assertion failed");

// next-cycle implication, disabled in reset
`define TLM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlm assertion failed");

`endif

[rtl/core/tlm_pkg.sv]
// types, constants and saturating helpers for the tof to momentum solver
// no dependencies
package tlm_pkg;

  localparam int MAX_ITERATIONS = 100;
  localparam int STEP_W = $clog2(MAX_ITERATIONS + 1);

  localparam logic signed [63:0] Q_ONE = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] S_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S_MIN = 64'sh8000_0000_0000_0000;

  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_ITER_LIMIT = 2'd1;
  localparam logic [1:0] ST_NEG_RADICAND = 2'd2;
  localparam logic [1:0] ST_ZERO_DIVISOR = 2'd3;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_GAIN1 = 3'd1;
  localparam logic [2:0] REG_GAIN2 = 3'd2;
  localparam logic [2:0] REG_GAIN3 = 3'd3;
  localparam logic [2:0] REG_FORCE1 = 3'd4;
  localparam logic [2:0] REG_FORCE2 = 3'd5;
  localparam logic [2:0] REG_FORCE3 = 3'd6;
  localparam logic [2:0] REG_DRIFT = 3'd7;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_NEG,
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_t;

  typedef struct packed {
    logic start;
    alu_op_t op;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic signed [63:0] y;
  } alu_rsp_t;

  function automatic logic signed [63:0] sadd(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? S_MIN : S_MAX;
    return s;
  endfunction

  function automatic logic signed [63:0] ssub(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] d;
    d = a - b;
    if (a[63] != b[63] && d[63] != a[63]) return a[63] ? S_MIN : S_MAX;
    return d;
  endfunction

  function automatic logic signed [63:0] sneg(logic signed [63:0] a);
    return (a == S_MIN) ? S_MAX : -a;
  endfunction

  function automatic logic [63:0] mag(logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [63:0] from_mag(logic neg, logic [63:0] m);
    if (neg) return m[63] ? S_MIN : -$signed(m);
    return m[63] ? S_MAX : $signed(m);
  endfunction

endpackage

[rtl/core/tlm_if.sv]
// request channel interfaces for the tof to momentum solver
// depends on nothing but plain logic types
interface tlm_tof_if;
  logic valid;
  logic ready;
  logic signed [63:0] tof_measured;
  modport source(output valid, output tof_measured, input ready);
  modport sink(input valid, input tof_measured, output ready);
endinterface

interface tlm_result_if;
  logic valid;
  logic ready;
  logic signed [63:0] momentum_z;
  logic [6:0] iterations_used;
  logic [1:0] status;
  modport source(output valid, output momentum_z, output iterations_used, output status,
                 input ready);
  modport sink(input valid, input momentum_z, input iterations_used, input status,
               output ready);
endinterface

interface tlm_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [63:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

[rtl/core/tlm_alu.sv]
// shared arithmetic unit: saturating add/sub/neg, multiply from four 32x32 partial products,
// 64-step restoring divide, 48-step digit square root; uses tlm_pkg
module tlm_alu (
  input  logic clk,
  input  logic rst,
  input  tlm_pkg::alu_req_t req,
  output tlm_pkg::alu_rsp_t rsp
);
  import tlm_pkg::*;

  typedef enum logic [2:0] {A_IDLE, A_MUL, A_MUL_FIN, A_DIV, A_SQRT} astate_t;

  astate_t state;
  logic [6:0] cnt;
  logic neg;
  logic [127:0] acc;
  logic [63:0] ma, mb, d, r, lo, q;
  logic [49:0] rem;
  logic [47:0] root;
  logic [95:0] nbuf;

  logic [63:0] pp;
  logic [127:0] pp_sh;
  logic [64:0] rr;
  logic [51:0] rem_n;
  logic [51:0] trial;
  logic [63:0] mul_m;

  always_comb begin
    case (cnt[1:0])
      2'd0: pp = ma[31:0] * mb[31:0];
      2'd1: pp = ma[31:0] * mb[63:32];
      2'd2: pp = ma[63:32] * mb[31:0];
      default: pp = ma[63:32] * mb[63:32];
    endcase
    case (cnt[1:0])
      2'd0: pp_sh = {64'd0, pp};
      2'd3: pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    mul_m = (acc[127:96] != 32'd0) ? '1 : acc[95:32];
    rr = {r, lo[63]};
    rem_n = {rem, nbuf[95:94]};
    trial = {2'b00, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    rsp.done <= 1'b0;
    if (rst) begin
      state <= A_IDLE;
      cnt <= '0;
    end else begin
      unique case (state)
        A_IDLE: begin
          if (req.start) begin
            neg <= req.a[63] ^ req.b[63];
            cnt <= '0;
            unique case (req.op)
              OP_ADD: begin
                rsp.y <= sadd(req.a, req.b);
                rsp.done <= 1'b1;
              end
              OP_SUB: begin
                rsp.y <= ssub(req.a, req.b);
                rsp.done <= 1'b1;
              end
              OP_NEG: begin
                rsp.y <= sneg(req.a);
                rsp.done <= 1'b1;
              end
              OP_MUL: begin
                ma <= mag(req.a);
                mb <= mag(req.b);
                acc <= '0;
                state <= A_MUL;
              end
              OP_DIV: begin
                d <= mag(req.b);
                q <= '0;
                // quotient overflow saturates at once
                if (mag(req.a) >> 32 >= mag(req.b)) begin
                  rsp.y <= from_mag(req.a[63] ^ req.b[63], '1);
                  rsp.done <= 1'b1;
                end else begin
                  r <= mag(req.a) >> 32;
                  lo <= mag(req.a) << 32;
                  state <= A_DIV;
                end
              end
              default: begin
                nbuf <= {req.a, 32'd0};
                rem <= '0;
                root <= '0;
                state <= A_SQRT;
              end
            endcase
          end
        end
        A_MUL: begin
          acc <= acc + pp_sh;
          cnt <= cnt + 7'd1;
          if (cnt[1:0] == 2'd3) state <= A_MUL_FIN;
        end
        A_MUL_FIN: begin
          // divide finishes here too, with its quotient after 64 steps
          rsp.y <= from_mag(neg, (cnt == 7'd64) ? q : mul_m);
          rsp.done <= 1'b1;
          state <= A_IDLE;
        end
        A_DIV: begin
          lo <= {lo[62:0], 1'b0};
          if (rr >= {1'b0, d}) begin
            r <= 64'(rr - {1'b0, d});
            q <= {q[62:0], 1'b1};
          end else begin
            r <= rr[63:0];
            q <= {q[62:0], 1'b0};
          end
          cnt <= cnt + 7'd1;
          if (cnt == 7'd63) state <= A_MUL_FIN;
          if (cnt == 7'd63) begin
            acc <= '0;
          end
        end
        A_SQRT: begin
          nbuf <= {nbuf[93:0], 2'b00};
          if (rem_n >= trial) begin
            rem <= 50'(rem_n - trial);
            root <= {root[46:0], 1'b1};
          end else begin
            rem <= rem_n[49:0];
            root <= {root[46:0], 1'b0};
          end
          cnt <= cnt + 7'd1;
          if (cnt == 7'd47) state <= A_IDLE;
          if (cnt == 7'd47) begin
            rsp.done <= 1'b1;
            rsp.y <= $signed({16'd0, root[46:0], (rem_n >= trial)});
          end
        end
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/tof_to_longitudinal_momentum.sv]
// top level of the tof to longitudinal momentum solver
// depends on tlm_pkg, tlm_if and tlm_alu
//
// Solves T(p0) = tof_measured for the initial longitudinal momentum p0 by
// Newton iteration starting at p0 = 0, at most MAX_ITERATIONS (100) steps,
// stopping when an update leaves p0 unchanged. All values are signed Q32.32
// with saturating arithmetic. Mode 0 (ion) models three accelerating
// regions, mode 1 (electron) one region plus a drift. Configuration writes
// are taken at any time and must only be issued while the block is idle.
// One request is solved at a time: tof.ready is high only while idle. All
// arithmetic runs on a single shared unit (tlm_alu): add/sub/neg, multiply
// (four 32x32 partial products), divide (one quotient bit a cycle) and
// square root (one root bit a cycle). One Newton step uses 3 roots, 4
// divides, 7 multiplies and 16 add/sub/neg in ion mode, and 1 root, 5
// divides, 4 multiplies and 8 add/sub/neg in electron mode. The result sits
// in an output register so the next request is accepted while it waits.
// Status: 0 converged, 1 iteration limit, 2 negative radicand, 3 zero
// divisor; on error momentum_z is the last completed iterate.
module tof_to_longitudinal_momentum (
  input  logic clk,
  input  logic rst,
  tlm_tof_if.sink tof,
  tlm_result_if.source result,
  tlm_cfg_if.sink cfg
);
  import tlm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE, S_SQ, S_R1, S_S1, S_A1,
    S_E1, S_E2, S_E3, S_E4, S_E5, S_E6, S_E7, S_E8, S_E9, S_E10,
    S_I1, S_I2, S_I3, S_I4, S_I5, S_I6, S_I7, S_I8, S_I9, S_I10, S_I11,
    S_I12, S_I13, S_I14, S_I15, S_I16, S_I17, S_I18, S_I19, S_I20, S_I21, S_I22,
    S_N1, S_N2, S_N3, S_N4, S_DONE
  } state_t;

  state_t state;
  logic issued;

  // configuration registers
  logic mode;
  logic signed [63:0] gain1, gain2, gain3, force1, force2, force3, drift;

  // solver working registers
  logic signed [63:0] x, tgt, r1, r2, r3, s1, s2, s3, a1, a2, a3, t, dt, tmp, t2;
  logic [STEP_W-1:0] steps;
  logic [1:0] fin_status;

  // output register
  logic res_valid;
  logic signed [63:0] res_mom;
  logic [6:0] res_iter;
  logic [1:0] res_status;

  alu_req_t req;
  alu_rsp_t rsp;
  alu_op_t op;
  logic signed [63:0] opa, opb;
  logic compute;
  logic [STEP_W-1:0] steps_inc;

  tlm_alu u_alu (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  assign tof.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign result.valid = res_valid;
  assign result.momentum_z = res_mom;
  assign result.iterations_used = res_iter;
  assign result.status = res_status;
  assign steps_inc = steps + 1'b1;

  // operation schedule: one shared-unit request per compute state
  always_comb begin
    op = OP_ADD;
    opa = tmp;
    opb = t2;
    compute = 1'b1;
    unique case (state)
      S_SQ:  begin op = OP_MUL;  opa = x;      opb = x;     end
      S_R1:  begin op = OP_ADD;  opa = tmp;    opb = gain1; end
      S_S1:  begin op = OP_SQRT; opa = r1;                  end
      S_A1:  begin op = OP_DIV;  opa = x;      opb = s1;    end
      S_E1:  begin op = OP_SUB;  opa = s1;     opb = x;     end
      S_E2:  begin op = OP_MUL;  opa = force1; opb = tmp;   end
      S_E3:  begin op = OP_DIV;  opa = drift;  opb = s1;    end
      S_E4:  begin op = OP_ADD;  opa = tmp;    opb = t2;    end
      S_E5:  begin op = OP_MUL;  opa = drift;  opb = x;     end
      S_E6:  begin op = OP_DIV;  opa = tmp;    opb = r1;    end
      S_E7:  begin op = OP_DIV;  opa = tmp;    opb = s1;    end
      S_E8:  begin op = OP_SUB;  opa = a1;     opb = Q_ONE; end
      S_E9:  begin op = OP_MUL;  opa = force1; opb = t2;    end
      S_E10: begin op = OP_SUB;  opa = t2;     opb = tmp;   end
      S_I1:  begin op = OP_ADD;  opa = r1;     opb = gain2; end
      S_I2:  begin op = OP_ADD;  opa = r2;     opb = gain3; end
      S_I3:  begin op = OP_SQRT; opa = r2;                  end
      S_I4:  begin op = OP_SQRT; opa = r3;                  end
      S_I5:  begin op = OP_DIV;  opa = x;      opb = s2;    end
      S_I6:  begin op = OP_DIV;  opa = x;      opb = s3;    end
      S_I7:  begin op = OP_SUB;  opa = s1;     opb = x;     end
      S_I8:  begin op = OP_MUL;  opa = force1; opb = tmp;   end
      S_I9:  begin op = OP_SUB;  opa = s2;     opb = s1;    end
      S_I10: begin op = OP_MUL;  opa = force2; opb = tmp;   end
      S_I11: begin op = OP_ADD;  opa = t;      opb = tmp;   end
      S_I12: begin op = OP_SUB;  opa = s3;     opb = s2;    end
      S_I13: begin op = OP_MUL;  opa = force3; opb = tmp;   end
      S_I14: begin op = OP_ADD;  opa = t;      opb = tmp;   end
      S_I15: begin op = OP_SUB;  opa = a1;     opb = Q_ONE; end
      S_I16: begin op = OP_MUL;  opa = force1; opb = tmp;   end
      S_I17: begin op = OP_SUB;  opa = a2;     opb = a1;    end
      S_I18: begin op = OP_MUL;  opa = force2; opb = tmp;   end
      S_I19: begin op = OP_ADD;  opa = dt;     opb = tmp;   end
      S_I20: begin op = OP_SUB;  opa = a3;     opb = a2;    end
      S_I21: begin op = OP_MUL;  opa = force3; opb = tmp;   end
      S_I22: begin op = OP_ADD;  opa = dt;     opb = tmp;   end
      S_N1:  begin op = OP_SUB;  opa = t;      opb = tgt;   end
      S_N2:  begin op = OP_DIV;  opa = tmp;    opb = dt;    end
      S_N3:  begin op = OP_NEG;  opa = tmp;                 end
      S_N4:  begin op = OP_ADD;  opa = x;      opb = tmp;   end
      default: compute = 1'b0;
    endcase
    req.start = compute && !issued && !(state == S_N1 && dt == 64'sd0);
    req.op = op;
    req.a = opa;
    req.b = opb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      issued <= 1'b0;
      res_valid <= 1'b0;
      mode <= 1'b0;
      gain1 <= '0;
      gain2 <= '0;
      gain3 <= '0;
      force1 <= '0;
      force2 <= '0;
      force3 <= '0;
      drift <= '0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_MODE:   mode <= cfg.data[0];
          REG_GAIN1:  gain1 <= $signed(cfg.data);
          REG_GAIN2:  gain2 <= $signed(cfg.data);
          REG_GAIN3:  gain3 <= $signed(cfg.data);
          REG_FORCE1: force1 <= $signed(cfg.data);
          REG_FORCE2: force2 <= $signed(cfg.data);
          REG_FORCE3: force3 <= $signed(cfg.data);
          REG_DRIFT:  drift <= $signed(cfg.data);
          default: ;
        endcase
      end

      if (result.ready) res_valid <= 1'b0;
      if (req.start) issued <= 1'b1;
      if (rsp.done) issued <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (tof.valid) begin
            tgt <= tof.tof_measured;
            x <= '0;
            steps <= '0;
            state <= S_SQ;
          end
        end
        S_DONE: begin
          if (!res_valid || result.ready) begin
            res_valid <= 1'b1;
            res_mom <= x;
            res_iter <= 7'(steps);
            res_status <= fin_status;
            state <= S_IDLE;
          end
        end
        S_N1: begin
          // flat derivative ends the solve
          if (!issued && dt == 64'sd0) begin
            fin_status <= ST_ZERO_DIVISOR;
            state <= S_DONE;
          end else if (rsp.done) begin
            tmp <= rsp.y;
            state <= S_N2;
          end
        end
        default: begin
          if (rsp.done) begin
            unique case (state)
              S_SQ: begin tmp <= rsp.y; state <= S_R1; end
              S_R1: begin
                r1 <= rsp.y;
                if (rsp.y < 0) begin
                  fin_status <= ST_NEG_RADICAND;
                  state <= S_DONE;
                end else state <= S_S1;
              end
              S_S1: begin
                s1 <= rsp.y;
                if (rsp.y == 64'sd0) begin
                  fin_status <= ST_ZERO_DIVISOR;
                  state <= S_DONE;
                end else state <= S_A1;
              end
              S_A1: begin a1 <= rsp.y; state <= mode ? S_E1 : S_I1; end
              S_E1:  begin tmp <= rsp.y; state <= S_E2; end
              S_E2:  begin tmp <= rsp.y; state <= S_E3; end
              S_E3:  begin t2 <= rsp.y; state <= S_E4; end
              S_E4:  begin t <= rsp.y; state <= S_E5; end
              S_E5:  begin tmp <= rsp.y; state <= S_E6; end
              S_E6:  begin tmp <= rsp.y; state <= S_E7; end
              S_E7:  begin tmp <= rsp.y; state <= S_E8; end
              S_E8:  begin t2 <= rsp.y; state <= S_E9; end
              S_E9:  begin t2 <= rsp.y; state <= S_E10; end
              S_E10: begin dt <= rsp.y; state <= S_N1; end
              S_I1: begin
                r2 <= rsp.y;
                if (rsp.y < 0) begin
                  fin_status <= ST_NEG_RADICAND;
                  state <= S_DONE;
                end else state <= S_I2;
              end
              S_I2: begin
                r3 <= rsp.y;
                if (rsp.y < 0) begin
                  fin_status <= ST_NEG_RADICAND;
                  state <= S_DONE;
                end else state <= S_I3;
              end
              S_I3: begin s2 <= rsp.y; state <= S_I4; end
              S_I4: begin
                s3 <= rsp.y;
                if (s2 == 64'sd0 || rsp.y == 64'sd0) begin
                  fin_status <= ST_ZERO_DIVISOR;
                  state <= S_DONE;
                end else state <= S_I5;
              end
              S_I5:  begin a2 <= rsp.y; state <= S_I6; end
              S_I6:  begin a3 <= rsp.y; state <= S_I7; end
              S_I7:  begin tmp <= rsp.y; state <= S_I8; end
              S_I8:  begin t <= rsp.y; state <= S_I9; end
              S_I9:  begin tmp <= rsp.y; state <= S_I10; end
              S_I10: begin tmp <= rsp.y; state <= S_I11; end
              S_I11: begin t <= rsp.y; state <= S_I12; end
              S_I12: begin tmp <= rsp.y; state <= S_I13; end
              S_I13: begin tmp <= rsp.y; state <= S_I14; end
              S_I14: begin t <= rsp.y; state <= S_I15; end
              S_I15: begin tmp <= rsp.y; state <= S_I16; end
              S_I16: begin dt <= rsp.y; state <= S_I17; end
              S_I17: begin tmp <= rsp.y; state <= S_I18; end
              S_I18: begin tmp <= rsp.y; state <= S_I19; end
              S_I19: begin dt <= rsp.y; state <= S_I20; end
              S_I20: begin tmp <= rsp.y; state <= S_I21; end
              S_I21: begin tmp <= rsp.y; state <= S_I22; end
              S_I22: begin dt <= rsp.y; state <= S_N1; end
              S_N2:  begin tmp <= rsp.y; state <= S_N3; end
              S_N3:  begin tmp <= rsp.y; state <= S_N4; end
              S_N4: begin
                // newton update, stop on a fixed point or at the step limit
                steps <= steps_inc;
                x <= rsp.y;
                if (rsp.y == x) begin
                  fin_status <= ST_CONVERGED;
                  state <= S_DONE;
                end else if (steps_inc == STEP_W'(MAX_ITERATIONS)) begin
                  fin_status <= ST_ITER_LIMIT;
                  state <= S_DONE;
                end else state <= S_SQ;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
      endcase
    end
  end

endmodule

[rtl/core/tlm_checker.sv]
// port-level checks for the tof to momentum solver, bound to the top level
// depends on tlm_pkg and tof_to_longitudinal_momentum_macros.svh
`include "tof_to_longitudinal_momentum_macros.svh"

module tlm_checker (
  input logic clk,
  input logic rst,
  input logic tof_valid,
  input logic tof_ready,
  input logic res_valid,
  input logic res_ready,
  input logic [6:0] res_iter,
  input logic [1:0] res_status
);
  import tlm_pkg::*;

  // a pending result stays offered
  `TLM_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid)
  // the solver is busy right after taking a request
  `TLM_ASSERT_NEXT(a_busy_after_req, clk, rst, tof_valid && tof_ready, !tof_ready)
  // convergence needs at least one step
  `TLM_ASSERT_IMPL(a_conv_steps, clk, rst, res_valid && res_status == ST_CONVERGED,
    res_iter != 7'd0)
  // hitting the limit means every step was used
  `TLM_ASSERT_IMPL(a_limit_steps, clk, rst, res_valid && res_status == ST_ITER_LIMIT,
    res_iter == 7'(MAX_ITERATIONS))

endmodule

bind tof_to_longitudinal_momentum tlm_checker u_tlm_checker (
  .clk(clk),
  .rst(rst),
  .tof_valid(tof.valid),
  .tof_ready(tof.ready),
  .res_valid(result.valid),
  .res_ready(result.ready),
  .res_iter(result.iterations_used),
  .res_status(result.status)
);
